FILE: src/apa_pkg.sv
// shared constants, types and the control store for the apa102 frame generator
// no dependencies; imported by apa_seq, apa102_led_frame_generator and the testbench
`timescale 1ns / 1ps

package apa_pkg;

   localparam int NUM_LEDS = 3;
   localparam int LED_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
   localparam int START_BYTES = 4;
   localparam int CNT_W = $clog2(START_BYTES);
   localparam int PC_W = 3;

   localparam logic [4:0] FULL_BRIGHT = 5'd31;
   localparam logic [7:0] HDR_MARK = 8'b1110_0000;
   localparam logic [7:0] BYTE_ZERO = 8'h00;
   localparam logic [7:0] BYTE_ONES = 8'hFF;

   // request codes
   localparam logic [1:0] REQ_SAMPLE = 2'd0;
   localparam logic [1:0] REQ_CHAN = 2'd1;
   localparam logic [1:0] REQ_LED = 2'd2;

   // byte source select
   localparam logic [2:0] SRC_ZERO = 3'd0;
   localparam logic [2:0] SRC_HDR = 3'd1;
   localparam logic [2:0] SRC_BLUE = 3'd2;
   localparam logic [2:0] SRC_GREEN = 3'd3;
   localparam logic [2:0] SRC_RED = 3'd4;
   localparam logic [2:0] SRC_ONES = 3'd5;

   // sequencing conditions
   localparam logic [1:0] COND_NEXT = 2'd0;
   localparam logic [1:0] COND_REPEAT = 2'd1;
   localparam logic [1:0] COND_LED = 2'd2;
   localparam logic [1:0] COND_DONE = 2'd3;

   typedef struct packed {
      logic [4:0] bright;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } led_type;

   typedef struct packed {
      logic [2:0] src;
      logic last;
      logic [1:0] cond;
      logic [PC_W-1:0] target;
   } ctrl_type;

   typedef struct packed {
      logic active;
      logic [2:0] src;
      logic last;
      logic [LED_W-1:0] led;
   } step_type;

   function automatic ctrl_type ucode_rom(input logic [PC_W-1:0] pc);
      ctrl_type w;
      w = '{src: SRC_ZERO, last: 1'b0, cond: COND_DONE, target: '0};
      case (pc)
         3'd0: w = '{src: SRC_ZERO, last: 1'b0, cond: COND_REPEAT, target: '0};
         3'd1: w = '{src: SRC_HDR, last: 1'b0, cond: COND_NEXT, target: '0};
         3'd2: w = '{src: SRC_BLUE, last: 1'b0, cond: COND_NEXT, target: '0};
         3'd3: w = '{src: SRC_GREEN, last: 1'b0, cond: COND_NEXT, target: '0};
         3'd4: w = '{src: SRC_RED, last: 1'b0, cond: COND_LED, target: 3'd1};
         3'd5: w = '{src: SRC_ONES, last: 1'b0, cond: COND_NEXT, target: '0};
         3'd6: w = '{src: SRC_ONES, last: 1'b1, cond: COND_DONE, target: '0};
         default: w = '{src: SRC_ZERO, last: 1'b0, cond: COND_DONE, target: '0};
      endcase
      return w;
   endfunction

endpackage

FILE: src/apa_seq.sv
// microcoded frame sequencer: step counter, repeat and led counters, control store
// depends on apa_pkg
`timescale 1ns / 1ps

module apa_seq (
   input logic clock,
   input logic reset,
   input logic go,
   output apa_pkg::step_type step_o
);
   import apa_pkg::*;

   logic [PC_W-1:0] pc_ff, pc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [LED_W-1:0] led_ff, led_in;
   logic run_ff, run_in;
   ctrl_type word;

   assign word = ucode_rom(pc_ff);

   always_comb begin
      pc_in = pc_ff;
      cnt_in = cnt_ff;
      led_in = led_ff;
      run_in = run_ff;
      if (go) begin
         run_in = 1'b1;
         pc_in = '0;
         cnt_in = '0;
         led_in = '0;
      end else if (run_ff) begin
         case (word.cond)
            COND_NEXT: pc_in = pc_ff + PC_W'(1);
            COND_REPEAT: begin
               if (cnt_ff == CNT_W'(START_BYTES - 1)) begin
                  cnt_in = '0;
                  pc_in = pc_ff + PC_W'(1);
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
            COND_LED: begin
               if (led_ff == LED_W'(NUM_LEDS - 1)) begin
                  led_in = '0;
                  pc_in = pc_ff + PC_W'(1);
               end else begin
                  led_in = led_ff + LED_W'(1);
                  pc_in = word.target;
               end
            end
            COND_DONE: run_in = 1'b0;
            default: run_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
         cnt_ff <= '0;
         led_ff <= '0;
         run_ff <= 1'b0;
      end else begin
         pc_ff <= pc_in;
         cnt_ff <= cnt_in;
         led_ff <= led_in;
         run_ff <= run_in;
      end
   end

   assign step_o.active = run_ff;
   assign step_o.src = word.src;
   assign step_o.last = word.last;
   assign step_o.led = led_ff;

endmodule

FILE: src/apa102_led_frame_generator.sv
// top level: led color store, button handling, frame byte output
// depends on apa_pkg and apa_seq
`timescale 1ns / 1ps

// A level sample (req_type 0) is accepted when start is high and busy is low. It
// updates the selected channel of the selected led, sets that led to full
// brightness, and then produces one frame of 4 + 4*NUM_LEDS + 2 bytes (18 for three
// leds), one byte per cycle on rsp_spi_byte with rsp_strobe high, the first byte on
// the ports from the clock edge that follows the accepting edge. rsp_last_byte marks
// the final end byte. busy stays high while the microprogram steps through the
// frame, one step per byte, and the next item can be accepted as soon as busy is
// low again, so a new sample is taken only once the sequencer is through the last
// frame; button presses (req_type 1 and 2) are taken when busy is low and produce
// nothing, and req_type 3 is ignored. The receiver cannot stall: every strobed byte
// must be taken in its cycle.
module apa102_led_frame_generator (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input logic [1:0] req_type,
   input logic [7:0] req_sample,
   output logic rsp_strobe,
   output logic [7:0] rsp_spi_byte,
   output logic rsp_last_byte
);
   import apa_pkg::*;

   localparam logic [1:0] CHAN_RED = 2'd0;
   localparam logic [1:0] CHAN_GREEN = 2'd1;
   localparam logic [1:0] CHAN_BLUE = 2'd2;

   led_type led_store_ff [NUM_LEDS];
   led_type led_store_in [NUM_LEDS];
   logic [LED_W-1:0] sel_led_ff, sel_led_in;
   logic [1:0] sel_chan_ff, sel_chan_in;
   logic strobe_ff, strobe_in;
   logic [7:0] byte_ff, byte_in;
   logic last_ff, last_in;
   logic accept;
   logic go;
   step_type step;
   led_type cur;

   apa_seq u_seq (
      .clock(clock),
      .reset(reset),
      .go(go),
      .step_o(step)
   );

   assign busy = step.active;
   assign accept = start && !step.active;
   assign go = accept && (req_type == REQ_SAMPLE);

   always_comb begin
      led_store_in = led_store_ff;
      sel_led_in = sel_led_ff;
      sel_chan_in = sel_chan_ff;
      if (accept) begin
         case (req_type)
            REQ_SAMPLE: begin
               case (sel_chan_ff)
                  CHAN_RED: led_store_in[sel_led_ff].red = req_sample;
                  CHAN_GREEN: led_store_in[sel_led_ff].green = req_sample;
                  CHAN_BLUE: led_store_in[sel_led_ff].blue = req_sample;
                  default: ;
               endcase
               led_store_in[sel_led_ff].bright = FULL_BRIGHT;
            end
            REQ_CHAN: sel_chan_in = (sel_chan_ff == CHAN_BLUE) ? CHAN_RED
                                                               : sel_chan_ff + 2'd1;
            REQ_LED: sel_led_in = (sel_led_ff == LED_W'(NUM_LEDS - 1)) ? '0
                                                                        : sel_led_ff + LED_W'(1);
            default: ;
         endcase
      end
   end

   assign cur = led_store_ff[step.led];

   always_comb begin
      strobe_in = step.active;
      last_in = step.active && step.last;
      case (step.src)
         SRC_ZERO: byte_in = BYTE_ZERO;
         SRC_HDR: byte_in = HDR_MARK | {3'b000, cur.bright};
         SRC_BLUE: byte_in = cur.blue;
         SRC_GREEN: byte_in = cur.green;
         SRC_RED: byte_in = cur.red;
         SRC_ONES: byte_in = BYTE_ONES;
         default: byte_in = BYTE_ZERO;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LEDS; i++) begin
            led_store_ff[i] <= '0;
         end
         sel_led_ff <= '0;
         sel_chan_ff <= CHAN_RED;
         strobe_ff <= 1'b0;
         last_ff <= 1'b0;
      end else begin
         led_store_ff <= led_store_in;
         sel_led_ff <= sel_led_in;
         sel_chan_ff <= sel_chan_in;
         strobe_ff <= strobe_in;
         last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_spi_byte = byte_ff;
   assign rsp_last_byte = last_ff;

endmodule

FILE: bench/tb_apa102_led_frame_generator.sv
// testbench for apa102_led_frame_generator: drives samples and button presses, predicts
// each frame byte and checks it. depends on apa_pkg and the generator rtl in src
`timescale 1ns / 1ps

module tb_apa102_led_frame_generator;
   import apa_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 24;
   localparam int MAX_PRINTED = 30;

   typedef enum logic [1:0] {CH_RED, CH_GREEN, CH_BLUE} channel_type;

   typedef struct {
      logic [7:0] spi_byte;
      logic last_byte;
   } frame_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic [1:0] req_type = REQ_SAMPLE;
   logic [7:0] req_sample = 8'h00;
   logic busy;
   logic rsp_strobe;
   logic [7:0] rsp_spi_byte;
   logic rsp_last_byte;

   led_type strip [NUM_LEDS];
   logic [LED_W-1:0] cur_led;
   channel_type cur_chan;
   frame_byte_type frame_bytes_q[$];

   int idle_pct = 0;
   int mismatches = 0;
   int stall_cycles = 0;
   int samples_sent = 0;
   int presses_sent = 0;
   int ignored_sent = 0;
   int bytes_checked = 0;

   apa102_led_frame_generator dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_type(req_type),
      .req_sample(req_sample),
      .rsp_strobe(rsp_strobe),
      .rsp_spi_byte(rsp_spi_byte),
      .rsp_last_byte(rsp_last_byte)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void push_frame_byte(input logic [7:0] value, input logic last);
      frame_byte_type b;
      b.spi_byte = value;
      b.last_byte = last;
      frame_bytes_q.push_back(b);
   endfunction

   // updates the led state for one item and queues the frame it causes
   function automatic void apply_event(input logic [1:0] kind, input logic [7:0] level);
      case (kind)
         REQ_CHAN: begin
            case (cur_chan)
               CH_RED: cur_chan = CH_GREEN;
               CH_GREEN: cur_chan = CH_BLUE;
               default: cur_chan = CH_RED;
            endcase
         end
         REQ_LED: begin
            cur_led = (cur_led == NUM_LEDS - 1) ? '0 : cur_led + 1'b1;
         end
         REQ_SAMPLE: begin
            case (cur_chan)
               CH_RED: strip[cur_led].red = level;
               CH_GREEN: strip[cur_led].green = level;
               default: strip[cur_led].blue = level;
            endcase
            strip[cur_led].bright = FULL_BRIGHT;
            for (int i = 0; i < START_BYTES; i++) begin
               push_frame_byte(BYTE_ZERO, 1'b0);
            end
            for (int i = 0; i < NUM_LEDS; i++) begin
               push_frame_byte(HDR_MARK | {3'b000, strip[i].bright}, 1'b0);
               push_frame_byte(strip[i].blue, 1'b0);
               push_frame_byte(strip[i].green, 1'b0);
               push_frame_byte(strip[i].red, 1'b0);
            end
            push_frame_byte(BYTE_ONES, 1'b0);
            push_frame_byte(BYTE_ONES, 1'b1);
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      mismatches++;
      if (mismatches <= MAX_PRINTED) begin
         $display("mismatch at %0t: %s got %02h expected %02h", $realtime, what, got, want);
      end
   endtask

   // called at a rising edge; returns at the edge that accepts the item
   task automatic send_item(input logic [1:0] kind, input logic [7:0] level);
      logic taken;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_type <= kind;
      req_sample <= level;
      do begin
         @(negedge clock);
         taken = (busy === 1'b0);
         @(posedge clock);
      end while (!taken);
      apply_event(kind, level);
      case (kind)
         REQ_SAMPLE: samples_sent++;
         REQ_CHAN, REQ_LED: presses_sent++;
         default: ignored_sent++;
      endcase
   endtask

   always @(negedge clock) begin
      frame_byte_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (frame_bytes_q.size() == 0) begin
            report_mismatch("byte with no frame pending", rsp_spi_byte, 8'h00);
         end else begin
            want = frame_bytes_q.pop_front();
            bytes_checked++;
            if (rsp_spi_byte !== want.spi_byte) begin
               report_mismatch("spi_byte", rsp_spi_byte, want.spi_byte);
            end
            if (rsp_last_byte !== want.last_byte) begin
               report_mismatch("last_byte", {7'b0, rsp_last_byte}, {7'b0, want.last_byte});
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset || rsp_strobe === 1'b1 || (start && busy === 1'b0)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no item or byte moved for %0d cycles", WATCHDOG_LIMIT);
         $display("tb_apa102_led_frame_generator: FAIL");
         $finish;
      end
   end

   task automatic test_extreme_levels();
      send_item(REQ_SAMPLE, 8'h00);
      send_item(REQ_SAMPLE, 8'hFF);
   endtask

   task automatic test_channel_cycle();
      send_item(REQ_CHAN, 8'h00);
      send_item(REQ_SAMPLE, 8'h55);
      send_item(REQ_CHAN, 8'h00);
      send_item(REQ_SAMPLE, 8'hAA);
      // wraps back to red
      send_item(REQ_CHAN, 8'h00);
      send_item(REQ_SAMPLE, 8'h0F);
   endtask

   task automatic test_led_wrap();
      send_item(REQ_LED, 8'h00);
      send_item(REQ_SAMPLE, 8'hF0);
      for (int i = 1; i < NUM_LEDS; i++) begin
         send_item(REQ_LED, 8'h00);
         send_item(REQ_SAMPLE, 8'h7E ^ 8'(i));
      end
   endtask

   task automatic test_ignored_requests();
      send_item(REQ_UNUSED, 8'hFF);
      send_item(REQ_UNUSED, 8'h00);
      send_item(REQ_CHAN, 8'hFF);
      send_item(REQ_LED, 8'hA5);
      send_item(REQ_SAMPLE, 8'h3C);
   endtask

   task automatic test_random_traffic(input int count, input int pct);
      int sent;
      int pick;
      sent = 0;
      idle_pct = pct;
      while (sent < count) begin
         pick = $urandom_range(99);
         if (pick < 50) begin
            send_item(REQ_SAMPLE, 8'($urandom_range(255)));
            sent++;
         end else if (pick < 70) begin
            send_item(REQ_CHAN, 8'($urandom_range(255)));
            sent++;
         end else if (pick < 90) begin
            send_item(REQ_LED, 8'($urandom_range(255)));
            sent++;
         end else begin
            send_item(REQ_UNUSED, 8'($urandom_range(255)));
         end
      end
   endtask

   initial begin
      foreach (strip[i]) begin
         strip[i] = '0;
      end
      cur_led = '0;
      cur_chan = CH_RED;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_extreme_levels();
      test_channel_cycle();
      test_led_wrap();
      test_ignored_requests();
      test_random_traffic(75, 0);
      test_random_traffic(75, 46);
      test_random_traffic(75, 0);
      test_random_traffic(75, 9);

      start <= 1'b0;
      while (frame_bytes_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d samples, %0d button presses, %0d unused requests",
               samples_sent, presses_sent, ignored_sent);
      $display("checked %0d frame bytes, %0d mismatches", bytes_checked, mismatches);
      if (mismatches == 0) begin
         $display("tb_apa102_led_frame_generator: PASS");
      end else begin
         $display("tb_apa102_led_frame_generator: FAIL");
      end
      $finish;
   end

endmodule
